/* src/assert_macros.svh */
// assertion macros for the rtl of the scrollback terminal
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(label, ante, cons)
`define ASSERT_NEVER(label, expr)
`endif
`endif

/* src/tts_pkg.sv */
// types, codes and defaults of the scrollback terminal
// no dependencies
`default_nettype none

package tts_pkg;

	localparam int COLUMNS_DEF      = 40;
	localparam int ROWS_DEF         = 20;
	localparam int HISTORY_ROWS_DEF = 64;

	localparam int CODE_W    = 5;
	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_BACKSPACE,
		REG_SCROLL_UP,
		REG_SCROLL_DOWN,
		REG_LEFT_KEY,
		REG_RIGHT_KEY
	} reg_idx_t;

	localparam logic [CODE_W-1:0] BACKSPACE_RST   = 5'd8;
	localparam logic [CODE_W-1:0] SCROLL_UP_RST   = 5'd17;
	localparam logic [CODE_W-1:0] SCROLL_DOWN_RST = 5'd18;
	localparam logic [CODE_W-1:0] LEFT_KEY_RST    = 5'd19;
	localparam logic [CODE_W-1:0] RIGHT_KEY_RST   = 5'd20;

	localparam logic [7:0] CHAR_BLANK    = 8'h20;
	localparam logic [7:0] CHAR_PRINT_LO = 8'h20;
	localparam logic [7:0] CHAR_PRINT_HI = 8'h7F;

	typedef struct packed {
		logic       req_type;
		logic [7:0] char_code;
		logic [4:0] view_row;
		logic [5:0] view_col;
	} req_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [9:0] cursor_pos;
		logic [6:0] scroll_rows;
	} rsp_t;

	typedef enum logic [2:0] {
		K_PRINT,
		K_BACKSPACE,
		K_SCROLL_UP,
		K_SCROLL_DOWN,
		K_IGNORE,
		K_PAD,
		K_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] char_code;
		logic [4:0] view_row;
		logic [5:0] view_col;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} fe_cmd_t;

	typedef struct packed {
		logic take;
		logic clearing;
	} bk_ctl_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PRINT,
		ST_BACKSPACE,
		ST_BLANK,
		ST_PAD,
		ST_SHIFT,
		ST_SHIFT_END,
		ST_READ,
		ST_READ_WAIT,
		ST_DONE
	} bk_state_t;

endpackage

`default_nettype wire

/* src/tts_front.sv */
// front end: key code registers, request classification and a two-entry command queue
// depends on tts_pkg
`default_nettype none

module tts_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire tts_pkg::req_t                 req,
	input  wire logic                          cfg_we,
	input  wire logic [tts_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [tts_pkg::CODE_W-1:0]    cfg_data,
	input  wire tts_pkg::bk_ctl_t              ctl,
	output tts_pkg::fe_cmd_t                   fe
);

	logic [tts_pkg::CODE_W-1:0] bs_code_q;
	logic [tts_pkg::CODE_W-1:0] up_code_q;
	logic [tts_pkg::CODE_W-1:0] down_code_q;
	logic [tts_pkg::CODE_W-1:0] left_code_q;
	logic [tts_pkg::CODE_W-1:0] right_code_q;

	tts_pkg::cmd_kind_t kind;
	tts_pkg::cmd_t      cmd_in;
	tts_pkg::cmd_t      fifo_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               push_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_code_q    <= tts_pkg::BACKSPACE_RST;
			up_code_q    <= tts_pkg::SCROLL_UP_RST;
			down_code_q  <= tts_pkg::SCROLL_DOWN_RST;
			left_code_q  <= tts_pkg::LEFT_KEY_RST;
			right_code_q <= tts_pkg::RIGHT_KEY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tts_pkg::REG_BACKSPACE:   bs_code_q    <= cfg_data;
				tts_pkg::REG_SCROLL_UP:   up_code_q    <= cfg_data;
				tts_pkg::REG_SCROLL_DOWN: down_code_q  <= cfg_data;
				tts_pkg::REG_LEFT_KEY:    left_code_q  <= cfg_data;
				tts_pkg::REG_RIGHT_KEY:   right_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// priority: read, printable, backspace, scroll up, scroll down, arrows, pad
	always_comb begin
		kind = tts_pkg::K_PAD;
		if (req.req_type) begin
			kind = tts_pkg::K_READ;
		end else if (req.char_code inside {[tts_pkg::CHAR_PRINT_LO:tts_pkg::CHAR_PRINT_HI]}) begin
			kind = tts_pkg::K_PRINT;
		end else if (req.char_code == 8'(bs_code_q)) begin
			kind = tts_pkg::K_BACKSPACE;
		end else if (req.char_code == 8'(up_code_q)) begin
			kind = tts_pkg::K_SCROLL_UP;
		end else if (req.char_code == 8'(down_code_q)) begin
			kind = tts_pkg::K_SCROLL_DOWN;
		end else if (req.char_code == 8'(left_code_q) || req.char_code == 8'(right_code_q)) begin
			kind = tts_pkg::K_IGNORE;
		end
	end

	assign cmd_in = '{kind: kind, char_code: req.char_code,
		view_row: req.view_row, view_col: req.view_col};

	assign full    = (cnt_q == 2'd2) || ctl.clearing;
	assign push_ok = push && !full;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (ctl.take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push_ok && !ctl.take) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push_ok && ctl.take) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign fe.valid = (cnt_q != 2'd0);
	assign fe.cmd   = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

/* src/tts_back.sv */
// back end: screen and history memories, cursor and scroll state, command sequencer
// and the result register; depends on tts_pkg
`default_nettype none

module tts_back #(
	parameter int COLUMNS      = tts_pkg::COLUMNS_DEF,
	parameter int ROWS         = tts_pkg::ROWS_DEF,
	parameter int HISTORY_ROWS = tts_pkg::HISTORY_ROWS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire tts_pkg::fe_cmd_t fe,
	output tts_pkg::bk_ctl_t ctl,
	input  wire logic       pop,
	output logic            empty,
	output tts_pkg::rsp_t   rsp
);

	localparam int COL_W     = $clog2(COLUMNS);
	localparam int ROW_W     = $clog2(ROWS);
	localparam int HROW_W    = $clog2(HISTORY_ROWS);
	localparam int SCR_SIZE  = COLUMNS * ROWS;
	localparam int HIST_SIZE = COLUMNS * HISTORY_ROWS;
	localparam int SA_W      = $clog2(SCR_SIZE);
	localparam int HA_W      = $clog2(HIST_SIZE);
	localparam int SC_W      = $clog2(HISTORY_ROWS + 1);
	localparam int SSUM_W    = $clog2(2 * ROWS);
	localparam int HSUM_W    = $clog2(2 * HISTORY_ROWS);
	localparam int CLR_N     = (SCR_SIZE > HIST_SIZE) ? SCR_SIZE : HIST_SIZE;
	localparam int CLR_W     = $clog2(CLR_N);

	tts_pkg::bk_state_t state_q, state_d;

	logic [ROW_W-1:0]  cur_row_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  top_q;
	logic [HROW_W-1:0] head_q;
	logic [SC_W-1:0]   scroll_q;
	logic [CLR_W-1:0]  clr_q;
	logic [COL_W-1:0]  sh_col_q;
	logic              sh_wr_s1;
	logic [COL_W-1:0]  sh_col_s1;
	tts_pkg::cmd_t     cmd_q;
	logic [7:0]        cell_q;
	logic              rd_hist_q;
	tts_pkg::rsp_t     res_q;
	logic              res_valid_q;

	logic [7:0] scr_mem  [SCR_SIZE];
	logic [7:0] hist_mem [HIST_SIZE];

	logic            scr_we, scr_re, hist_we, hist_re, take, load;
	logic [SA_W-1:0] scr_waddr, scr_raddr;
	logic [HA_W-1:0] hist_waddr, hist_raddr;
	logic [7:0]      scr_wdata, hist_wdata;
	logic [7:0]      scr_rdata_q, hist_rdata_q;

	logic              col_last, row_last, cur_zero;
	logic [SSUM_W-1:0] cur_sum, s_diff, s_sum;
	logic [ROW_W-1:0]  cur_prow, s_prow;
	logic [SA_W-1:0]   cur_addr, cur_lin, top_base, rd_scr_addr;
	logic [HSUM_W-1:0] h_off, h_sum;
	logic [HROW_W-1:0] h_prow;
	logic [HA_W-1:0]   rd_hist_addr, hist_wr_addr;
	logic              rd_oob, rd_in_hist;

	assign col_last = (cur_col_q == COL_W'(COLUMNS - 1));
	assign row_last = (cur_row_q == ROW_W'(ROWS - 1));
	assign cur_zero = (cur_row_q == '0) && (cur_col_q == '0);

	// cursor cell, physical screen row is rotated by the top pointer
	assign cur_sum  = SSUM_W'(top_q) + SSUM_W'(cur_row_q);
	assign cur_prow = ROW_W'((cur_sum >= SSUM_W'(ROWS)) ? cur_sum - SSUM_W'(ROWS) : cur_sum);
	assign cur_addr = SA_W'(cur_prow) * SA_W'(COLUMNS) + SA_W'(cur_col_q);
	assign cur_lin  = SA_W'(cur_row_q) * SA_W'(COLUMNS) + SA_W'(cur_col_q);

	assign top_base     = SA_W'(top_q) * SA_W'(COLUMNS);
	assign hist_wr_addr = HA_W'(head_q) * HA_W'(COLUMNS) + HA_W'(sh_col_s1);

	// window read
	assign rd_oob     = (int'(cmd_q.view_row) >= ROWS) || (int'(cmd_q.view_col) >= COLUMNS);
	assign rd_in_hist = int'(cmd_q.view_row) < int'(scroll_q);

	assign h_off  = HSUM_W'(HISTORY_ROWS) - HSUM_W'(scroll_q) + HSUM_W'(cmd_q.view_row);
	assign h_sum  = HSUM_W'(head_q) + h_off;
	assign h_prow = HROW_W'((h_sum >= HSUM_W'(HISTORY_ROWS)) ?
		h_sum - HSUM_W'(HISTORY_ROWS) : h_sum);
	assign rd_hist_addr = HA_W'(h_prow) * HA_W'(COLUMNS) + HA_W'(cmd_q.view_col);

	assign s_diff = SSUM_W'(cmd_q.view_row) - SSUM_W'(scroll_q);
	assign s_sum  = SSUM_W'(top_q) + s_diff;
	assign s_prow = ROW_W'((s_sum >= SSUM_W'(ROWS)) ? s_sum - SSUM_W'(ROWS) : s_sum);
	assign rd_scr_addr = SA_W'(s_prow) * SA_W'(COLUMNS) + SA_W'(cmd_q.view_col);

	assign load = (state_q == tts_pkg::ST_DONE) && (!res_valid_q || pop);

	always_comb begin
		state_d = state_q;
		case (state_q)
			tts_pkg::ST_CLEAR: begin
				if (clr_q == CLR_W'(CLR_N - 1)) begin
					state_d = tts_pkg::ST_IDLE;
				end
			end
			tts_pkg::ST_IDLE: begin
				if (fe.valid) begin
					case (fe.cmd.kind)
						tts_pkg::K_PRINT:     state_d = tts_pkg::ST_PRINT;
						tts_pkg::K_BACKSPACE: state_d = tts_pkg::ST_BACKSPACE;
						tts_pkg::K_PAD:       state_d = tts_pkg::ST_PAD;
						tts_pkg::K_READ:      state_d = tts_pkg::ST_READ;
						default:              state_d = tts_pkg::ST_DONE;
					endcase
				end
			end
			tts_pkg::ST_PRINT: begin
				state_d = (col_last && row_last) ? tts_pkg::ST_SHIFT : tts_pkg::ST_DONE;
			end
			tts_pkg::ST_BACKSPACE: begin
				state_d = cur_zero ? tts_pkg::ST_DONE : tts_pkg::ST_BLANK;
			end
			tts_pkg::ST_BLANK: begin
				state_d = tts_pkg::ST_DONE;
			end
			tts_pkg::ST_PAD: begin
				if (cur_col_q == '0) begin
					state_d = tts_pkg::ST_DONE;
				end else if (col_last && row_last) begin
					state_d = tts_pkg::ST_SHIFT;
				end
			end
			tts_pkg::ST_SHIFT: begin
				if (sh_col_q == COL_W'(COLUMNS - 1)) begin
					state_d = tts_pkg::ST_SHIFT_END;
				end
			end
			tts_pkg::ST_SHIFT_END: begin
				state_d = tts_pkg::ST_DONE;
			end
			tts_pkg::ST_READ: begin
				state_d = rd_oob ? tts_pkg::ST_DONE : tts_pkg::ST_READ_WAIT;
			end
			tts_pkg::ST_READ_WAIT: begin
				state_d = tts_pkg::ST_DONE;
			end
			tts_pkg::ST_DONE: begin
				if (!res_valid_q || pop) begin
					state_d = tts_pkg::ST_IDLE;
				end
			end
			default: state_d = tts_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		take       = 1'b0;
		scr_we     = 1'b0;
		scr_waddr  = cur_addr;
		scr_wdata  = tts_pkg::CHAR_BLANK;
		scr_re     = 1'b0;
		scr_raddr  = rd_scr_addr;
		hist_we    = 1'b0;
		hist_waddr = hist_wr_addr;
		hist_wdata = scr_rdata_q;
		hist_re    = 1'b0;
		hist_raddr = rd_hist_addr;
		case (state_q)
			tts_pkg::ST_CLEAR: begin
				scr_we     = int'(clr_q) < SCR_SIZE;
				scr_waddr  = clr_q[SA_W-1:0];
				scr_wdata  = 8'h00;
				hist_we    = int'(clr_q) < HIST_SIZE;
				hist_waddr = clr_q[HA_W-1:0];
				hist_wdata = 8'h00;
			end
			tts_pkg::ST_IDLE: begin
				take = fe.valid;
			end
			tts_pkg::ST_PRINT: begin
				scr_we    = 1'b1;
				scr_wdata = cmd_q.char_code;
			end
			tts_pkg::ST_BLANK: begin
				scr_we = 1'b1;
			end
			tts_pkg::ST_PAD: begin
				scr_we = (cur_col_q != '0);
			end
			tts_pkg::ST_SHIFT, tts_pkg::ST_SHIFT_END: begin
				scr_re    = (state_q == tts_pkg::ST_SHIFT);
				scr_raddr = top_base + SA_W'(sh_col_q);
				scr_we    = sh_wr_s1;
				scr_waddr = top_base + SA_W'(sh_col_s1);
				hist_we   = sh_wr_s1;
			end
			tts_pkg::ST_READ: begin
				hist_re = !rd_oob && rd_in_hist;
				scr_re  = !rd_oob && !rd_in_hist;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (scr_we) begin
			scr_mem[scr_waddr] <= scr_wdata;
		end
		if (scr_re) begin
			scr_rdata_q <= scr_mem[scr_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		if (hist_re) begin
			hist_rdata_q <= hist_mem[hist_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tts_pkg::ST_CLEAR;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			top_q       <= '0;
			head_q      <= '0;
			scroll_q    <= '0;
			clr_q       <= '0;
			sh_col_q    <= '0;
			sh_wr_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			sh_wr_s1 <= (state_q == tts_pkg::ST_SHIFT);
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				tts_pkg::ST_CLEAR: begin
					clr_q <= clr_q + CLR_W'(1);
				end
				tts_pkg::ST_IDLE: begin
					sh_col_q <= '0;
					if (fe.valid && fe.cmd.kind == tts_pkg::K_SCROLL_UP &&
							scroll_q < SC_W'(HISTORY_ROWS)) begin
						scroll_q <= scroll_q + SC_W'(1);
					end
					if (fe.valid && fe.cmd.kind == tts_pkg::K_SCROLL_DOWN &&
							scroll_q != '0) begin
						scroll_q <= scroll_q - SC_W'(1);
					end
				end
				tts_pkg::ST_PRINT, tts_pkg::ST_PAD: begin
					if (state_q == tts_pkg::ST_PRINT || cur_col_q != '0) begin
						if (col_last) begin
							cur_col_q <= '0;
							if (!row_last) begin
								cur_row_q <= cur_row_q + ROW_W'(1);
							end
						end else begin
							cur_col_q <= cur_col_q + COL_W'(1);
						end
					end
				end
				tts_pkg::ST_BACKSPACE: begin
					if (!cur_zero) begin
						if (cur_col_q == '0) begin
							cur_col_q <= COL_W'(COLUMNS - 1);
							cur_row_q <= cur_row_q - ROW_W'(1);
						end else begin
							cur_col_q <= cur_col_q - COL_W'(1);
						end
					end
				end
				tts_pkg::ST_SHIFT: begin
					sh_col_q <= sh_col_q + COL_W'(1);
				end
				tts_pkg::ST_SHIFT_END: begin
					head_q <= (head_q == HROW_W'(HISTORY_ROWS - 1)) ? '0 : head_q + HROW_W'(1);
					top_q  <= (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + ROW_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		sh_col_s1 <= sh_col_q;
		if (state_q == tts_pkg::ST_IDLE && fe.valid) begin
			cmd_q  <= fe.cmd;
			cell_q <= 8'h00;
		end
		if (state_q == tts_pkg::ST_READ) begin
			rd_hist_q <= rd_in_hist;
		end
		if (state_q == tts_pkg::ST_READ_WAIT) begin
			cell_q <= rd_hist_q ? hist_rdata_q : scr_rdata_q;
		end
		if (load) begin
			res_q <= '{cell_char: cell_q, cursor_pos: 10'(cur_lin), scroll_rows: 7'(scroll_q)};
		end
	end

	assign ctl.take     = take;
	assign ctl.clearing = (state_q == tts_pkg::ST_CLEAR);
	assign empty        = !res_valid_q;
	assign rsp          = res_q;

endmodule

`default_nettype wire

/* src/text_terminal_scrollback_core.sv */
// top level of the scrollback terminal: front end, command queue and back end
// depends on tts_pkg, tts_front, tts_back and assert_macros.svh
`default_nettype none

// Character terminal with a ROWS x COLUMNS screen and a HISTORY_ROWS deep scrollback.
// After reset the block clears both memories, one cell per cycle, over
// max(COLUMNS*ROWS, COLUMNS*HISTORY_ROWS) cells and holds full high meanwhile.
// Requests queue in a two-entry command buffer and run one at a time in the back end,
// which owns the single-write, single-read screen and history memories. When the screen
// fills after a printable or a line pad, the top row moves into history one cell per
// cycle through the memory ports. A finished result waits in an output register until
// popped, while new requests keep queueing.

`include "assert_macros.svh"

module text_terminal_scrollback_core #(
	parameter int COLUMNS      = tts_pkg::COLUMNS_DEF,
	parameter int ROWS         = tts_pkg::ROWS_DEF,
	parameter int HISTORY_ROWS = tts_pkg::HISTORY_ROWS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire tts_pkg::req_t                 req,
	output logic                               empty,
	input  wire logic                          pop,
	output tts_pkg::rsp_t                      rsp,
	input  wire logic                          cfg_we,
	input  wire logic [tts_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [tts_pkg::CODE_W-1:0]    cfg_data
);

	tts_pkg::fe_cmd_t fe;
	tts_pkg::bk_ctl_t ctl;

	tts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.fe        (fe)
	);

	tts_back #(
		.COLUMNS      (COLUMNS),
		.ROWS         (ROWS),
		.HISTORY_ROWS (HISTORY_ROWS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.fe     (fe),
		.ctl    (ctl),
		.pop    (pop),
		.empty  (empty),
		.rsp    (rsp)
	);

	`ASSERT_NEVER(a_take_without_cmd, ctl.take && !fe.valid)
	`ASSERT_IMPLY(a_clear_blocks_push, ctl.clearing, full)
	`ASSERT_IMPLY(a_clear_no_result, ctl.clearing, empty)

endmodule

`default_nettype wire

/* dv/tb_text_terminal_scrollback_core.sv */
// self-checking testbench for text_terminal_scrollback_core: random and directed put/read beats
// checked against an in-bench model of the screen, the history ring and the scroll offset
// depends on tts_pkg and the rtl of the scrollback terminal
`default_nettype none

module tb_text_terminal_scrollback_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCOL         = tts_pkg::COLUMNS_DEF;
	localparam int NROW         = tts_pkg::ROWS_DEF;
	localparam int NHIST        = tts_pkg::HISTORY_ROWS_DEF;
	localparam int SCREEN_CELLS = NCOL * NROW;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int TAIL_CYCLES  = 120;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          push      = 1'b0;
	logic                          pop       = 1'b0;
	logic                          cfg_we    = 1'b0;
	logic [tts_pkg::REG_IDX_W-1:0] cfg_index = '0;
	logic [tts_pkg::CODE_W-1:0]    cfg_data  = '0;
	tts_pkg::req_t                 req_in    = '0;
	logic                          full;
	logic                          empty;
	tts_pkg::rsp_t                 rsp_out;

	text_terminal_scrollback_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req_in),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// terminal model state
	logic [7:0]  screen_mem [SCREEN_CELLS];
	logic [7:0]  history_mem [NCOL*NHIST];
	int unsigned top_row;
	int unsigned head_row;
	int unsigned cursor;
	int unsigned offset_rows;
	logic [4:0]  bs_code, up_code, dn_code, lf_code, rt_code;

	tts_pkg::req_t req_queue[$];
	tts_pkg::rsp_t expected_rsp[$];
	int            items_queued;
	int            fail_count;
	int            rsp_beats;
	int            cycle_count;
	int            send_gap, send_burst;
	int            recv_gap, recv_burst, recv_hold;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned screen_at(int unsigned row, int unsigned col);
		return ((top_row + row) % NROW) * NCOL + col;
	endfunction

	function automatic void screen_write(int unsigned idx, logic [7:0] v);
		if (idx < SCREEN_CELLS)
			screen_mem[screen_at(idx / NCOL, idx % NCOL)] = v;
	endfunction

	function automatic void term_reset();
		foreach (screen_mem[i]) screen_mem[i] = '0;
		foreach (history_mem[i]) history_mem[i] = '0;
		top_row     = 0;
		head_row    = 0;
		cursor      = 0;
		offset_rows = 0;
		bs_code     = tts_pkg::BACKSPACE_RST;
		up_code     = tts_pkg::SCROLL_UP_RST;
		dn_code     = tts_pkg::SCROLL_DOWN_RST;
		lf_code     = tts_pkg::LEFT_KEY_RST;
		rt_code     = tts_pkg::RIGHT_KEY_RST;
	endfunction

	function automatic tts_pkg::rsp_t term_apply(tts_pkg::req_t r);
		tts_pkg::rsp_t res;
		int unsigned   row;
		int unsigned   col;
		res = '0;
		if (!r.req_type) begin
			if (r.char_code >= tts_pkg::CHAR_PRINT_LO && r.char_code <= tts_pkg::CHAR_PRINT_HI) begin
				screen_write(cursor, r.char_code);
				cursor++;
			end else if (r.char_code == 8'(bs_code)) begin
				if (cursor > 0) begin
					cursor--;
					screen_write(cursor, tts_pkg::CHAR_BLANK);
				end
			end else if (r.char_code == 8'(up_code)) begin
				if (offset_rows < NHIST)
					offset_rows++;
			end else if (r.char_code == 8'(dn_code)) begin
				if (offset_rows > 0)
					offset_rows--;
			end else if (r.char_code == 8'(lf_code) || r.char_code == 8'(rt_code)) begin
			end else begin
				while (cursor % NCOL != 0 && cursor < SCREEN_CELLS) begin
					screen_write(cursor, tts_pkg::CHAR_BLANK);
					cursor++;
				end
			end
			if (cursor >= SCREEN_CELLS) begin
				// top row goes to history, blank row opens at the bottom
				for (int c = 0; c < NCOL; c++)
					history_mem[head_row * NCOL + c] = screen_mem[screen_at(0, c)];
				head_row = (head_row + 1) % NHIST;
				for (int c = 0; c < NCOL; c++)
					screen_mem[screen_at(0, c)] = tts_pkg::CHAR_BLANK;
				top_row = (top_row + 1) % NROW;
				cursor  = SCREEN_CELLS - NCOL;
			end
		end else begin
			row = 32'(r.view_row);
			col = 32'(r.view_col);
			if (row < NROW && col < NCOL) begin
				if (row < offset_rows)
					res.cell_char = history_mem[((head_row + NHIST - offset_rows + row) % NHIST)
						* NCOL + col];
				else
					res.cell_char = screen_mem[screen_at(row - offset_rows, col)];
			end
		end
		res.cursor_pos  = cursor[9:0];
		res.scroll_rows = offset_rows[6:0];
		return res;
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void queue_put(logic [7:0] ch);
		tts_pkg::req_t r;
		r.req_type  = 1'b0;
		r.char_code = ch;
		r.view_row  = 5'($urandom_range(0, 31));
		r.view_col  = 6'($urandom_range(0, 63));
		req_queue.push_back(r);
		items_queued++;
	endfunction

	function automatic void queue_read(int unsigned row, int unsigned col);
		tts_pkg::req_t r;
		r.req_type  = 1'b1;
		r.char_code = 8'($urandom_range(0, 255));
		r.view_row  = 5'(row);
		r.view_col  = 6'(col);
		req_queue.push_back(r);
		items_queued++;
	endfunction

	function automatic logic [7:0] line_end_byte();
		int unsigned r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return 8'($urandom_range(0, 31));
		else if (r == 1)
			return 8'($urandom_range(8'h80, 8'hFF));
		return 8'h0A;
	endfunction

	function automatic void queue_random_reads(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				queue_read($urandom_range(0, 31), $urandom_range(0, 63));
			else
				queue_read($urandom_range(0, NROW-1), $urandom_range(0, NCOL-1));
		end
	endfunction

	function automatic void gen_random(int target);
		int            kind;
		int            n;
		tts_pkg::req_t r;
		n = 0;
		target += items_queued;
		while (items_queued < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				// text line, occasional backspace, then a line end
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 90) : $urandom_range(1, 40);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 9) == 0)
						queue_put(8'(bs_code));
					else
						queue_put(8'($urandom_range(8'h20, 8'h7F)));
				end
				queue_put(line_end_byte());
			end else if (kind < 60) begin
				// scroll back, look around, scroll forward
				n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					queue_put(8'(up_code));
				queue_random_reads($urandom_range(1, 6));
				n = $urandom_range(0, n + 3);
				for (int i = 0; i < n; i++)
					queue_put(8'(dn_code));
			end else if (kind < 85) begin
				queue_random_reads($urandom_range(1, 8));
			end else begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++) begin
					r.req_type  = 1'($urandom_range(0, 1));
					r.char_code = 8'($urandom_range(0, 255));
					r.view_row  = 5'($urandom_range(0, 31));
					r.view_col  = 6'($urandom_range(0, 63));
					req_queue.push_back(r);
					items_queued++;
				end
			end
		end
	endfunction

	task automatic write_code(tts_pkg::reg_idx_t idx, logic [4:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_codes(logic [4:0] bs, logic [4:0] up, logic [4:0] dn,
		logic [4:0] lf, logic [4:0] rt);
		write_code(tts_pkg::REG_BACKSPACE, bs);
		write_code(tts_pkg::REG_SCROLL_UP, up);
		write_code(tts_pkg::REG_SCROLL_DOWN, dn);
		write_code(tts_pkg::REG_LEFT_KEY, lf);
		write_code(tts_pkg::REG_RIGHT_KEY, rt);
		bs_code = bs;
		up_code = up;
		dn_code = dn;
		lf_code = lf;
		rt_code = rt;
	endtask

	// checked between edges so that the driver's updates have settled
	task automatic drain();
		while (req_queue.size() != 0 || push || expected_rsp.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// request side
	always @(posedge clk) begin : drive_proc
		bit push_nxt;
		if (arst_n) begin
			push_nxt = push;
			if (push && !full) begin
				expected_rsp.push_back(term_apply(req_in));
				push_nxt = 1'b0;
				if (send_burst > 0) begin
					send_burst--;
					send_gap = 0;
				end else begin
					send_gap = pick_gap();
					if ($urandom_range(0, 15) == 0)
						send_burst = $urandom_range(20, 60);
				end
			end
			if (!push_nxt) begin
				if (send_gap > 0)
					send_gap--;
				else if (req_queue.size() != 0) begin
					req_in   <= req_queue.pop_front();
					push_nxt = 1'b1;
				end
			end
			push <= push_nxt;
		end
	end

	// result side
	always @(posedge clk) begin : recv_proc
		tts_pkg::rsp_t want;
		bit            pop_nxt;
		if (arst_n) begin
			pop_nxt = pop;
			if (pop && !empty) begin
				rsp_beats++;
				if (expected_rsp.size() == 0) begin
					$display("%0t: unexpected beat, expected none actual %p", $time, rsp_out);
					fail_count++;
				end else begin
					want = expected_rsp.pop_front();
					check_field("cell_char", 32'(want.cell_char), 32'(rsp_out.cell_char));
					check_field("cursor_pos", 32'(want.cursor_pos), 32'(rsp_out.cursor_pos));
					check_field("scroll_rows", 32'(want.scroll_rows), 32'(rsp_out.scroll_rows));
				end
				// one long hold-off so the request side backs up
				if (rsp_beats == 100)
					recv_hold = 500;
				pop_nxt = 1'b0;
				if (recv_burst > 0) begin
					recv_burst--;
					recv_gap = 0;
				end else begin
					recv_gap = pick_gap();
					if ($urandom_range(0, 15) == 0)
						recv_burst = $urandom_range(20, 60);
				end
			end
			if (!pop_nxt) begin
				if (recv_hold > 0)
					recv_hold--;
				else if (recv_gap > 0)
					recv_gap--;
				else
					pop_nxt = 1'b1;
			end
			pop <= pop_nxt;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		term_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// edge cases at the reset codes
		queue_read(0, 0);
		queue_read(NROW-1, NCOL-1);
		queue_read(NROW, 0);
		queue_read(31, 63);
		queue_put(8'(tts_pkg::BACKSPACE_RST));
		queue_put(8'h0A);
		queue_put(8'(tts_pkg::SCROLL_DOWN_RST));
		queue_put(8'(tts_pkg::LEFT_KEY_RST));
		queue_put(8'(tts_pkg::RIGHT_KEY_RST));
		queue_put("A");
		queue_put(8'h20);
		queue_put(8'h7F);
		queue_put(8'(tts_pkg::BACKSPACE_RST));
		queue_put(8'h00);
		queue_put("B");
		queue_put(8'hFF);
		queue_put("C");
		queue_put(8'h80);
		queue_put("D");
		queue_put(8'h1F);
		queue_put(8'(tts_pkg::SCROLL_UP_RST));
		queue_read(0, 0);
		queue_read(1, 0);
		queue_put(8'(tts_pkg::SCROLL_DOWN_RST));
		gen_random(140);
		drain();

		set_codes(5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
		gen_random(180);
		drain();
		set_codes(5'd31, 5'd31, 5'd31, 5'd31, 5'd31);
		gen_random(180);
		drain();
		set_codes(5'd31, 5'd0, 5'd1, 5'd2, 5'd3);
		gen_random(180);
		drain();
		set_codes(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
			5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
		gen_random(180);
		drain();
		set_codes(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
			5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
		gen_random(180);
		drain();
		set_codes(tts_pkg::BACKSPACE_RST, tts_pkg::SCROLL_UP_RST, tts_pkg::SCROLL_DOWN_RST,
			tts_pkg::LEFT_KEY_RST, tts_pkg::RIGHT_KEY_RST);
		gen_random(180);
		drain();

		if (expected_rsp.size() != 0) begin
			$display("%0t: %0d beats expected but never seen", $time, expected_rsp.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
